// ===== hw/rtl/hfv_pkg.sv =====
// Shared constants, arctangent table and register codes for the heading block.
package hfv_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int VEL_BITS_DEF     = 24;
    localparam int ANGLE_BITS_DEF   = 16;

    // Fractional guard bits added below the velocity LSB in the CORDIC datapath
    localparam int CORDIC_GUARD = 24;
    localparam int ATAN_ENTRIES = 24;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [31:0] HALF_TURN = 32'h80000000;

    typedef enum logic [0:0] {
        CFG_HEADING_OFFSET   = 1'b0,
        CFG_MIN_PLANAR_SPEED = 1'b1
    } cfg_reg_t;

endpackage

// ===== hw/rtl/hfv_cordic_stage.sv =====
// One registered vectoring iteration of the arctangent CORDIC.
module hfv_cordic_stage
    import hfv_pkg::*;
#(
    parameter int CW   = 51,
    parameter int STEP = 0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic        [31:0]   z_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic        [31:0]   z_out
);

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic        [31:0]   z_next;

    always_comb
    begin
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        // Rotate toward the x axis: clockwise while y is non-negative
        if (!y_in[CW-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_TURNS[STEP];
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out <= x_next;
            y_out <= y_next;
            z_out <= z_next;
        end
    end

endmodule

// ===== hw/rtl/heading_from_velocity.sv =====
// Heading-from-velocity top level: motion command pass-through with yaw override.
//
// Usage:
//   Input commands arrive as beats on s_axis_*; tdata packs lin_x, lin_y, lin_z,
//   roll, pitch, yaw from the lowest bit up. Results leave on m_axis_* in the
//   same packing, with tuser set when the yaw was replaced by the direction of
//   planar travel plus heading_offset. The user must write the registers on
//   cfg_* (index 0 heading_offset, index 1 min_planar_speed) only while no beat
//   is in flight; the block does not enforce it. Throughput is one beat per
//   clock while the receiver accepts results. Each beat passes one input stage,
//   one stage per CORDIC iteration and the output register; the planar-speed
//   squares are formed and compared alongside the first two iterations.
//   Each stage has its own valid bit and takes a new beat whenever it is empty
//   or its successor advances, so bubbles close up while the receiver stalls
//   and s_axis_tready falls only when every stage is full.
//   Reset clears all valid bits and sets both registers to zero.
module heading_from_velocity
    import hfv_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int VEL_BITS     = VEL_BITS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    localparam int PW    = 3 * VEL_BITS + 3 * ANGLE_BITS,
    localparam int TW    = ((PW + 7) / 8) * 8,
    localparam int CFG_W = (ANGLE_BITS > VEL_BITS - 1) ? ANGLE_BITS : VEL_BITS - 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // lin_x, lin_y, lin_z, ang_roll, ang_pitch, ang_yaw, zero padding
    input  logic [TW-1:0]    s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // out_lin_x, out_lin_y, out_lin_z, out_roll, out_pitch, out_yaw, zero padding
    output logic [TW-1:0]    m_axis_tdata,
    // yaw_overridden
    output logic             m_axis_tuser,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int CW    = VEL_BITS + CORDIC_GUARD + 3;
    localparam int SQW   = 2 * VEL_BITS;
    localparam int YAW_LO = 3 * VEL_BITS + 2 * ANGLE_BITS;
    localparam logic [31:0] Z_ROUND = 32'd1 << (31 - ANGLE_BITS);

    // Configuration registers
    logic [ANGLE_BITS-1:0] offset_reg;
    logic [VEL_BITS-2:0]   speed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            speed_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEADING_OFFSET:   offset_reg <= cfg_data[ANGLE_BITS-1:0];
                CFG_MIN_PLANAR_SPEED: speed_reg  <= cfg_data[VEL_BITS-2:0];
                default:              ;
            endcase
        end
    end

    // Pipeline control
    logic             vld_reg [0:NSTEP];
    logic             en      [0:NSTEP];
    logic             out_valid_reg;
    logic             en_out;

    always_comb
    begin
        en_out    = !out_valid_reg || m_axis_tready;
        en[NSTEP] = !vld_reg[NSTEP] || en_out;
        for (int k = NSTEP - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTEP; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k <= NSTEP; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (en_out)
            begin
                out_valid_reg <= vld_reg[NSTEP];
            end
        end
    end

    // Payload carried alongside the CORDIC stages
    logic [PW-1:0] pay_reg [0:NSTEP];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pay_reg[0] <= s_axis_tdata[PW-1:0];
        end
        for (int k = 1; k <= NSTEP; k++)
        begin
            if (en[k])
            begin
                pay_reg[k] <= pay_reg[k-1];
            end
        end
    end

    // Input stage: fold the left half-plane onto the right, add guard bits
    logic signed [VEL_BITS-1:0] in_x;
    logic signed [VEL_BITS-1:0] in_y;
    logic signed [CW-1:0]       ext_x;
    logic signed [CW-1:0]       ext_y;
    logic signed [CW-1:0]       rot_x;
    logic signed [CW-1:0]       rot_y;
    logic        [31:0]         rot_z;

    always_comb
    begin
        in_x  = s_axis_tdata[VEL_BITS-1:0];
        in_y  = s_axis_tdata[2*VEL_BITS-1:VEL_BITS];
        ext_x = {{(CW-VEL_BITS){in_x[VEL_BITS-1]}}, in_x};
        ext_y = {{(CW-VEL_BITS){in_y[VEL_BITS-1]}}, in_y};
        if (in_x[VEL_BITS-1])
        begin
            rot_x = -ext_x;
            rot_y = -ext_y;
            rot_z = HALF_TURN;
        end
        else
        begin
            rot_x = ext_x;
            rot_y = ext_y;
            rot_z = '0;
        end
    end

    logic signed [CW-1:0] cx [0:NSTEP];
    logic signed [CW-1:0] cy [0:NSTEP];
    logic        [31:0]   cz [0:NSTEP];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cx[0] <= rot_x <<< CORDIC_GUARD;
            cy[0] <= rot_y <<< CORDIC_GUARD;
            cz[0] <= rot_z;
        end
    end

    for (genvar g = 1; g <= NSTEP; g++)
    begin : g_iter
        hfv_cordic_stage #(
            .CW   (CW),
            .STEP (g - 1)
        ) u_stage (
            .clk   (clk),
            .en    (en[g]),
            .x_in  (cx[g-1]),
            .y_in  (cy[g-1]),
            .z_in  (cz[g-1]),
            .x_out (cx[g]),
            .y_out (cy[g]),
            .z_out (cz[g])
        );
    end

    // Planar speed test: squares in stage 1, compare in stage 2
    logic signed [VEL_BITS-1:0] sq_in_x;
    logic signed [VEL_BITS-1:0] sq_in_y;
    logic        [VEL_BITS-1:0] abs_x;
    logic        [VEL_BITS-1:0] abs_y;
    logic        [SQW-1:0]      sq_x_reg;
    logic        [SQW-1:0]      sq_y_reg;
    logic        [SQW-3:0]      sq_d_reg;
    logic        [SQW:0]        sq_sum;
    logic                       over_reg [2:NSTEP];

    always_comb
    begin
        sq_in_x = pay_reg[0][VEL_BITS-1:0];
        sq_in_y = pay_reg[0][2*VEL_BITS-1:VEL_BITS];
        abs_x   = sq_in_x[VEL_BITS-1] ? VEL_BITS'(-sq_in_x) : VEL_BITS'(sq_in_x);
        abs_y   = sq_in_y[VEL_BITS-1] ? VEL_BITS'(-sq_in_y) : VEL_BITS'(sq_in_y);
        sq_sum  = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sq_x_reg <= abs_x * abs_x;
            sq_y_reg <= abs_y * abs_y;
            sq_d_reg <= speed_reg * speed_reg;
        end
        if (en[2])
        begin
            over_reg[2] <= sq_sum > {3'b000, sq_d_reg};
        end
        for (int k = 3; k <= NSTEP; k++)
        begin
            if (en[k])
            begin
                over_reg[k] <= over_reg[k-1];
            end
        end
    end

    // Output stage: round the angle, add the offset, pick the yaw
    logic [31:0]           z_rnd;
    logic [ANGLE_BITS-1:0] new_yaw;
    logic [PW-1:0]         out_pay_next;
    logic [PW-1:0]         out_pay_reg;
    logic                  out_over_reg;

    always_comb
    begin
        z_rnd        = cz[NSTEP] + Z_ROUND;
        new_yaw      = z_rnd[31 -: ANGLE_BITS] + offset_reg;
        out_pay_next = pay_reg[NSTEP];
        if (over_reg[NSTEP])
        begin
            out_pay_next[PW-1:YAW_LO] = new_yaw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_pay_reg  <= out_pay_next;
            out_over_reg <= over_reg[NSTEP];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TW'(out_pay_reg);
    assign m_axis_tuser  = out_over_reg;

endmodule

// ===== hw/rtl/hfv_checker.sv =====
// Port-level checks for the heading block, bound to the top level.
module hfv_checker
    import hfv_pkg::*;
#(
    parameter int VEL_BITS   = VEL_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    localparam int TW = ((3 * VEL_BITS + 3 * ANGLE_BITS + 7) / 8) * 8
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [TW-1:0] m_axis_tdata,
    input logic          m_axis_tuser
);

    localparam logic [VEL_BITS-1:0] MOST_NEG = {1'b1, {(VEL_BITS-1){1'b0}}};

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // An open receiver must open the whole pipeline
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while receiver ready");

    // Zero planar velocity never replaces the yaw
    a_zero_keep: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2*VEL_BITS-1:0] == '0 |-> !m_axis_tuser)
        else $error("yaw replaced at zero velocity");

    // Full-scale negative forward speed always exceeds any threshold
    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[VEL_BITS-1:0] == MOST_NEG |-> m_axis_tuser)
        else $error("yaw kept at full-scale speed");

endmodule

bind heading_from_velocity hfv_checker #(
    .VEL_BITS   (VEL_BITS),
    .ANGLE_BITS (ANGLE_BITS)
) u_hfv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/testbench.sv =====
// Self-checking testbench for heading_from_velocity: stream driver, predictor and result monitor.
module testbench;
    import hfv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W  = ((3 * VEL_BITS_DEF + 3 * ANGLE_BITS_DEF + 7) / 8) * 8;
    localparam int CFG_W   = VEL_BITS_DEF - 1;
    localparam int VEL_MAX = (1 << (VEL_BITS_DEF - 1)) - 1;

    typedef struct {
        logic signed [VEL_BITS_DEF-1:0]   lin_x;
        logic signed [VEL_BITS_DEF-1:0]   lin_y;
        logic signed [VEL_BITS_DEF-1:0]   lin_z;
        logic signed [ANGLE_BITS_DEF-1:0] roll;
        logic signed [ANGLE_BITS_DEF-1:0] pitch;
        logic signed [ANGLE_BITS_DEF-1:0] yaw;
    } motion_cmd_t;

    typedef struct {
        motion_cmd_t cmd;
        logic        overridden;
    } steer_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_index = CFG_HEADING_OFFSET;
    logic [CFG_W-1:0]  cfg_data = '0;

    // Shadow copies of the block's registers
    logic [ANGLE_BITS_DEF-1:0] heading_offset_reg = '0;
    logic [CFG_W-1:0]          min_speed_reg = '0;

    motion_cmd_t   pending_cmds[$];
    steer_result_t expected_steer[$];
    motion_cmd_t   drive_cmd;
    steer_result_t want_steer;
    steer_result_t got_steer;
    int            sender_idle_pct = 17;
    int            receiver_idle_pct = 50;
    int            mismatch_count = 0;

    heading_from_velocity u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic motion_cmd_t unpack_motion(logic [DATA_W-1:0] bits);
        motion_cmd_t c;
        c.lin_x = bits[23:0];
        c.lin_y = bits[47:24];
        c.lin_z = bits[71:48];
        c.roll  = bits[87:72];
        c.pitch = bits[103:88];
        c.yaw   = bits[119:104];
        return c;
    endfunction

    // Vectoring CORDIC: direction of (vx, vy) as a binary angle
    function automatic logic [ANGLE_BITS_DEF-1:0] velocity_heading(
        logic signed [VEL_BITS_DEF-1:0] vx, logic signed [VEL_BITS_DEF-1:0] vy);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        x = longint'(vx);
        y = longint'(vy);
        z = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        x = x <<< CORDIC_GUARD;
        y = y <<< CORDIC_GUARD;
        for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_ENTRIES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
        end
        z = z + (32'd1 << (31 - ANGLE_BITS_DEF));
        return z[31:32-ANGLE_BITS_DEF];
    endfunction

    function automatic steer_result_t predict_steer(motion_cmd_t c);
        steer_result_t r;
        longint        ax;
        longint        ay;
        longint        d;
        ax = (c.lin_x < 0) ? -longint'(c.lin_x) : longint'(c.lin_x);
        ay = (c.lin_y < 0) ? -longint'(c.lin_y) : longint'(c.lin_y);
        d = longint'(min_speed_reg);
        r.cmd = c;
        r.overridden = 1'b0;
        if (ax * ax + ay * ay > d * d)
        begin
            r.cmd.yaw = velocity_heading(c.lin_x, c.lin_y) + heading_offset_reg;
            r.overridden = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic void push_cmd(int x, int y, int z, int roll, int pitch, int yaw);
        motion_cmd_t c;
        c.lin_x = VEL_BITS_DEF'(x);
        c.lin_y = VEL_BITS_DEF'(y);
        c.lin_z = VEL_BITS_DEF'(z);
        c.roll  = ANGLE_BITS_DEF'(roll);
        c.pitch = ANGLE_BITS_DEF'(pitch);
        c.yaw   = ANGLE_BITS_DEF'(yaw);
        pending_cmds.push_back(c);
    endfunction

    function automatic void push_planar(int x, int y);
        push_cmd(x, y, $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic logic signed [VEL_BITS_DEF-1:0] random_velocity();
        logic signed [VEL_BITS_DEF-1:0] v;
        v = VEL_BITS_DEF'($urandom);
        case ($urandom_range(4))
            0: v = v >>> $urandom_range(23);
            1: v = v >>> $urandom_range(23, 12);
            2:
            begin
                case ($urandom_range(3))
                    0: v = 24'sh800000;
                    1: v = 24'sh7FFFFF;
                    2: v = '0;
                    default: v = -24'sd1;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic write_register(cfg_reg_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HEADING_OFFSET)
            heading_offset_reg = value[ANGLE_BITS_DEF-1:0];
        else
            min_speed_reg = value;
    endtask

    task automatic write_offset(logic signed [ANGLE_BITS_DEF-1:0] offset);
        write_register(CFG_HEADING_OFFSET, CFG_W'(offset));
    endtask

    // Hold until every queued command has gone in and every result has come back
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_steer.size() != 0)
            @(posedge clk);
    endtask

    // Input side: predict on each accepted beat, then offer the next command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_steer.push_back(predict_steer(unpack_motion(s_axis_tdata)));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    drive_cmd = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {drive_cmd.yaw, drive_cmd.pitch, drive_cmd.roll,
                                      drive_cmd.lin_z, drive_cmd.lin_y, drive_cmd.lin_x};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: compare each result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_steer.size() == 0)
                    report_mismatch("result beat with no command outstanding");
                else
                begin
                    want_steer = expected_steer.pop_front();
                    got_steer.cmd = unpack_motion(m_axis_tdata);
                    got_steer.overridden = m_axis_tuser;
                    check_field("out_lin_x", got_steer.cmd.lin_x, want_steer.cmd.lin_x);
                    check_field("out_lin_y", got_steer.cmd.lin_y, want_steer.cmd.lin_y);
                    check_field("out_lin_z", got_steer.cmd.lin_z, want_steer.cmd.lin_z);
                    check_field("out_roll", 24'(got_steer.cmd.roll),
                                24'(want_steer.cmd.roll));
                    check_field("out_pitch", 24'(got_steer.cmd.pitch),
                                24'(want_steer.cmd.pitch));
                    check_field("out_yaw", 24'(got_steer.cmd.yaw),
                                24'(want_steer.cmd.yaw));
                    check_field("yaw_overridden", 24'(got_steer.overridden),
                                24'(want_steer.overridden));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        int                             m;
        logic signed [VEL_BITS_DEF-1:0] v;
        logic [CFG_W-1:0]               speed;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values written back explicitly; zero velocity must keep the yaw
        write_offset(16'sd0);
        write_register(CFG_MIN_PLANAR_SPEED, '0);
        push_cmd(0, 0, -8388608, -32768, 32767, 12345);
        push_cmd(0, 0, 8388607, 32767, -32768, -32768);
        push_planar(1, 0);
        push_planar(0, 1);
        push_planar(-1, 0);
        push_planar(0, -1);
        push_planar(-8388608, -8388608);
        push_planar(8388607, 8388607);
        push_planar(-8388608, 8388607);
        push_planar(8388607, -8388608);
        push_planar(-5, 3);
        wait_drained();

        // Small threshold: equal magnitudes keep the yaw, larger ones replace it
        write_offset(16'sh7FFF);
        write_register(CFG_MIN_PLANAR_SPEED, 23'd5);
        push_planar(3, 4);
        push_planar(-3, -4);
        push_planar(5, 0);
        push_planar(0, -5);
        push_planar(3, 5);
        push_planar(-4, 3);
        push_planar(6, 0);
        wait_drained();

        // Largest threshold and most negative offset
        write_offset(-16'sh8000);
        write_register(CFG_MIN_PLANAR_SPEED, CFG_W'(VEL_MAX));
        push_planar(8388607, 0);
        push_planar(-8388608, 0);
        push_planar(0, -8388608);
        push_planar(8388607, 1);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    sender_idle_pct   = 17;
                    receiver_idle_pct = 50;
                end
                1:
                begin
                    sender_idle_pct   = 50;
                    receiver_idle_pct = 17;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            case ($urandom_range(3))
                0: speed = '0;
                1: speed = CFG_W'($urandom_range(VEL_MAX));
                default: speed = CFG_W'($urandom_range(VEL_MAX) >> $urandom_range(22));
            endcase
            write_offset(ANGLE_BITS_DEF'($urandom));
            write_register(CFG_MIN_PLANAR_SPEED, speed);
            for (int n = 0; n < 215; n++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // Sit on the threshold along one axis: equal or one step beyond
                    m = int'(min_speed_reg) + $urandom_range(1);
                    v = VEL_BITS_DEF'((m > VEL_MAX || $urandom_range(1)) ? -m : m);
                    if ($urandom_range(1))
                        push_planar(int'(v), 0);
                    else
                        push_planar(0, int'(v));
                end
                else
                    push_planar(int'(random_velocity()), int'(random_velocity()));
            end
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hfv_pkg.sv
hw/rtl/hfv_cordic_stage.sv
hw/rtl/heading_from_velocity.sv
hw/rtl/hfv_checker.sv
test/testbench.sv
